/* rtl/assert_macros.svh */
// Assertion macros shared by the connection table RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted
`define CTH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define CTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTH_ASSERT(lbl, clk, rstn, prop, msg)
`define CTH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/cth_pkg.sv */
// Types, codes and defaults for the connection table.
// No dependencies; imported by every module of the block but cth_ram.
`default_nettype none

package cth_pkg;

    localparam int ConnectionsDef = 8;
    localparam int TimeoutReset   = 1000;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_LISTEN  = 3'd1,
        OP_CLOSE   = 3'd2,
        OP_SEGMENT = 3'd3,
        OP_TICK    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_CLOSED    = 2'd0,
        ST_LISTENING = 2'd1,
        ST_CONNECTED = 2'd2,
        ST_CLOSEWAIT = 2'd3
    } t_conn_state;

    typedef enum logic [2:0] {
        SEG_SYN     = 3'd0,
        SEG_SYNACK  = 3'd1,
        SEG_FIN     = 3'd2,
        SEG_FINACK  = 3'd3,
        SEG_DATA    = 3'd4,
        SEG_DATAACK = 3'd5
    } t_seg;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_NO_MATCH = 3'd3,
        STS_BUSY     = 3'd4,
        STS_ODD      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_MODIFY,
        FSM_SCAN,
        FSM_DONE
    } t_fsm;

    // one slot as kept in the table RAM
    typedef struct packed {
        t_conn_state state;
        logic [15:0] srv_port;
        logic [15:0] client_port;
        logic [31:0] wait_base;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] local_port;
        logic [2:0]  seg_type;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dest_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot_index;
        logic [1:0]  slot_state;
        logic        slot_used;
        logic        reply_valid;
        logic [2:0]  reply_type;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dest_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
    } t_result;

    // per-entry evaluation handed from the match unit to the sequencer
    typedef struct packed {
        logic   hit;
        logic   expire;
        logic   reply_on;
        t_seg   reply_type;
        t_entry seg_entry;
    } t_check;

endpackage

`default_nettype wire

/* rtl/cth_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cth_match.sv */
// Match and update logic for one table entry: segment match, reply choice,
// updated entry, and close-wait expiry on a tick. Uses cth_pkg.
`default_nettype none

module cth_match
    import cth_pkg::*;
(
    input  wire t_entry      i_entry,
    input  wire logic        i_used,
    input  wire logic [2:0]  i_seg_type,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [31:0] i_tick,
    input  wire logic [15:0] i_timeout,
    output t_check           o_check
);

    logic        port_ok;
    logic        client_ok;
    logic [31:0] age;

    assign port_ok   = i_used && (i_entry.srv_port == i_dest_port);
    assign client_ok = (i_entry.client_port == i_src_port);
    assign age       = i_tick - i_entry.wait_base;

    always_comb begin
        o_check           = '0;
        o_check.seg_entry = i_entry;
        o_check.reply_type = SEG_SYNACK;

        o_check.hit = port_ok && (
            (i_seg_type == SEG_SYN && i_entry.state == ST_LISTENING) ||
            (i_entry.state == ST_CONNECTED && client_ok &&
                (i_seg_type == SEG_DATA || i_seg_type == SEG_FIN ||
                 i_seg_type == SEG_SYN)) ||
            (i_entry.state == ST_CLOSEWAIT && client_ok && i_seg_type == SEG_FIN));

        o_check.expire = i_used && (i_entry.state == ST_CLOSEWAIT) &&
                         (age > {16'd0, i_timeout});

        case (i_entry.state)
            ST_LISTENING: begin
                o_check.seg_entry.state       = ST_CONNECTED;
                o_check.seg_entry.client_port = i_src_port;
                o_check.reply_on              = 1'b1;
                o_check.reply_type            = SEG_SYNACK;
            end
            ST_CONNECTED: begin
                if (i_seg_type == SEG_FIN) begin
                    o_check.seg_entry.state     = ST_CLOSEWAIT;
                    o_check.seg_entry.wait_base = i_tick;
                    o_check.reply_on            = 1'b1;
                    o_check.reply_type          = SEG_FINACK;
                end else if (i_seg_type == SEG_SYN) begin
                    o_check.reply_on   = 1'b1;
                    o_check.reply_type = SEG_SYNACK;
                end
            end
            ST_CLOSEWAIT: begin
                // repeated FIN restarts the wait
                o_check.seg_entry.wait_base = i_tick;
                o_check.reply_on            = 1'b1;
                o_check.reply_type          = SEG_FINACK;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/cth_out_reg.sv */
// Output register of the result stream; packs a result into tdata/tuser.
// Uses cth_pkg.
`default_nettype none

module cth_out_reg
    import cth_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         m_axis_tvalid,
    input  wire logic    m_axis_tready,
    // slot_index, slot_state, slot_used, reply_valid, reply_type,
    // reply_src_port, reply_dest_port, reply_seq, reply_ack, zero pad
    output logic [111:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {6'd0, r_res.reply_ack, r_res.reply_seq,
                            r_res.reply_dest_port, r_res.reply_src_port,
                            r_res.reply_type, r_res.reply_valid, r_res.slot_used,
                            r_res.slot_state, r_res.slot_index};

endmodule

`default_nettype wire

/* rtl/connection_table_handshake.sv */
// Top level of the server connection table: sequencer, slot valid bits,
// tick counter and timeout register. Uses cth_pkg, cth_ram, cth_match, cth_out_reg.
//
// Usage
//   Command words enter on the s_axis channel, tuser carrying the op code
//   (open, listen, close, segment, tick). Every accepted word yields exactly one
//   result word on m_axis, tuser carrying the status.
//   i_cfg_valid/i_cfg_data write the close-wait timeout; o_cfg_ready is always
//   high. Write it only while the block is idle.
// Flow
//   One word is in work at a time. Open goes through decode and done into the
//   output register; listen and close on a valid slot add a modify state (one
//   read-modify-write of the slot RAM). Segment and tick walk the slot RAM one
//   entry per cycle through its single read port; tick reads every slot, and a
//   segment stops at the first matching slot.
//   The next word is taken at the earliest on the edge at which the result of
//   the word before can first be taken.
// Reset
//   i_rst_n is synchronous, active low. It frees all slots, zeroes the tick
//   counter and sets the timeout to 1000. Slot RAM is not cleared; a slot's
//   contents count only after open has written it.
// Stall
//   A finished result waits in the output register; the next word is accepted
//   meanwhile. If that word finishes while the register is still held, the
//   sequencer waits and s_axis_tready stays low.
`default_nettype none
`include "assert_macros.svh"

module connection_table_handshake
    import cth_pkg::*;
#(
    parameter int CONNECTIONS = ConnectionsDef
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // slot, local_port, seg_type, seg_src_port, seg_dest_port, seg_seq,
    // seg_ack, zero pad
    input  wire logic [119:0] s_axis_tdata,
    // op
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // slot_index, slot_state, slot_used, reply_valid, reply_type,
    // reply_src_port, reply_dest_port, reply_seq, reply_ack, zero pad
    output logic [111:0]      m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data
);

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int CW = $clog2(CONNECTIONS + 1);

    // sequencer state
    t_fsm r_fsm, n_fsm;

    t_item            r_item;
    logic [CONNECTIONS-1:0] r_valid, n_valid;
    logic [31:0]      r_tick, n_tick;
    logic [15:0]      r_timeout;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_chk_on, n_chk_on;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    t_result          r_res, n_res;

    // RAM port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;

    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             slot_ok;
    logic [AW-1:0]    slot_idx;
    logic             free_found;
    logic [AW-1:0]    free_idx;
    logic             scan_end;
    t_check           chk;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_fsm == FSM_IDLE);
    assign o_cfg_ready   = 1'b1;

    // addressed slot: in range and holding a connection
    assign slot_idx = AW'(r_item.slot);
    assign slot_ok  = (32'(r_item.slot) < CONNECTIONS) && r_valid[slot_idx];
    assign scan_end = !r_chk_on && (r_rd_idx == CW'(CONNECTIONS));

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CONNECTIONS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    cth_ram #(
        .WIDTH (EntryW),
        .DEPTH (CONNECTIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cth_match u_match (
        .i_entry     (ram_rdata),
        .i_used      (r_valid[r_chk_idx]),
        .i_seg_type  (r_item.seg_type),
        .i_src_port  (r_item.seg_src_port),
        .i_dest_port (r_item.seg_dest_port),
        .i_tick      (r_tick),
        .i_timeout   (r_timeout),
        .o_check     (chk)
    );

    cth_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_res         (r_res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // next state
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            FSM_IDLE: begin
                if (in_accept) begin
                    n_fsm = FSM_DECODE;
                end
            end
            FSM_DECODE: begin
                case (r_item.op)
                    OP_LISTEN, OP_CLOSE: n_fsm = slot_ok ? FSM_MODIFY : FSM_DONE;
                    OP_SEGMENT, OP_TICK: n_fsm = FSM_SCAN;
                    default:             n_fsm = FSM_DONE;
                endcase
            end
            FSM_MODIFY: begin
                n_fsm = FSM_DONE;
            end
            FSM_SCAN: begin
                if (r_chk_on && r_item.op == OP_SEGMENT && chk.hit) begin
                    n_fsm = FSM_DONE;
                end else if (scan_end) begin
                    n_fsm = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (out_free) begin
                    n_fsm = FSM_IDLE;
                end
            end
            default: n_fsm = FSM_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = slot_idx;
        n_valid   = r_valid;
        n_tick    = r_tick;
        n_rd_idx  = r_rd_idx;
        n_chk_on  = 1'b0;
        n_chk_idx = r_chk_idx;
        n_res     = r_res;
        out_load  = 1'b0;

        case (r_fsm)
            FSM_DECODE: begin
                n_res    = '0;
                n_rd_idx = '0;
                case (r_item.op)
                    OP_OPEN: begin
                        if (free_found) begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx;
                            ram_wdata = '{state: ST_CLOSED,
                                          srv_port: r_item.local_port,
                                          client_port: 16'd0,
                                          wait_base: 32'd0};
                            n_valid[free_idx] = 1'b1;
                            n_res.slot_index  = 3'(free_idx);
                            n_res.slot_used   = 1'b1;
                        end else begin
                            n_res.status = STS_FULL;
                        end
                    end
                    OP_LISTEN, OP_CLOSE: begin
                        n_res.slot_index = r_item.slot;
                        if (slot_ok) begin
                            ram_re = 1'b1;
                        end else begin
                            n_res.status = STS_EMPTY;
                        end
                    end
                    OP_SEGMENT: begin
                        // overwritten by a hit
                        n_res.status = STS_NO_MATCH;
                    end
                    OP_TICK: begin
                        n_tick = r_tick + 32'd1;
                    end
                    default: begin
                    end
                endcase
            end
            FSM_MODIFY: begin
                if (r_item.op == OP_LISTEN) begin
                    ram_we          = 1'b1;
                    ram_waddr       = slot_idx;
                    ram_wdata.state = ST_LISTENING;
                    n_res.slot_state = ST_LISTENING;
                    n_res.slot_used  = 1'b1;
                end else if (ram_rdata.state == ST_CLOSEWAIT) begin
                    n_res.status     = STS_BUSY;
                    n_res.slot_state = ST_CLOSEWAIT;
                    n_res.slot_used  = 1'b1;
                end else begin
                    // freed even when not cleanly closed
                    n_res.status = (ram_rdata.state != ST_CLOSED) ? STS_ODD : STS_OK;
                    n_valid[slot_idx] = 1'b0;
                end
            end
            FSM_SCAN: begin
                if (r_rd_idx < CW'(CONNECTIONS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_chk_on  = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                end
                if (r_chk_on) begin
                    if (r_item.op == OP_SEGMENT) begin
                        if (chk.hit) begin
                            ram_we    = 1'b1;
                            ram_wdata = chk.seg_entry;
                            n_res.status     = STS_OK;
                            n_res.slot_index = 3'(r_chk_idx);
                            n_res.slot_state = chk.seg_entry.state;
                            n_res.slot_used  = 1'b1;
                            if (chk.reply_on) begin
                                n_res.reply_valid     = 1'b1;
                                n_res.reply_type      = chk.reply_type;
                                n_res.reply_src_port  = r_item.seg_dest_port;
                                n_res.reply_dest_port = r_item.seg_src_port;
                                n_res.reply_seq       = r_item.seg_seq;
                                n_res.reply_ack       = r_item.seg_ack;
                            end
                        end
                    end else if (chk.expire) begin
                        ram_we          = 1'b1;
                        ram_wdata.state = ST_CLOSED;
                    end
                end
            end
            FSM_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= FSM_IDLE;
            r_valid   <= '0;
            r_tick    <= '0;
            r_timeout <= 16'(TimeoutReset);
            r_chk_on  <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_valid  <= n_valid;
            r_tick   <= n_tick;
            r_chk_on <= n_chk_on;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_res     <= n_res;
        if (in_accept) begin
            r_item <= '{op: s_axis_tuser,
                        slot: s_axis_tdata[2:0],
                        local_port: s_axis_tdata[18:3],
                        seg_type: s_axis_tdata[21:19],
                        seg_src_port: s_axis_tdata[37:22],
                        seg_dest_port: s_axis_tdata[53:38],
                        seg_seq: s_axis_tdata[85:54],
                        seg_ack: s_axis_tdata[117:86]};
        end
    end

    `CTH_ASSERT(a_ram_no_collide, i_clk, i_rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "ram read and write hit the same slot")
    `CTH_ASSERT(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second word taken while one is in work")
    `CTH_ASSERT(a_reply_only_seg, i_clk, i_rst_n, (out_load && r_res.reply_valid) |-> (r_item.op == OP_SEGMENT), "reply produced by a non-segment word")
    `CTH_ASSERT(a_modify_after_read, i_clk, i_rst_n, (r_fsm == FSM_MODIFY) |-> $past(ram_re), "modify without a preceding slot read")

endmodule

`default_nettype wire
